[src/fmsrd_pkg.sv]
package fmsrd_pkg;

  localparam int DIM_W   = 11;  // image_width / image_height / row_index
  localparam int COL_W   = 12;  // column may run past the row end by up to 128
  localparam int ADDR_W  = 21;
  localparam int RUN_W   = 7;   // run length / copy count, 1..64
  localparam int MAP_W   = 17;
  localparam int CFG_IDX_W = 2;

  localparam int HDR_BYTES = 4;
  localparam int HDR_W     = 3;

  localparam logic [DIM_W-1:0] IMAGE_WIDTH_RST  = 11'd24;
  localparam logic [DIM_W-1:0] IMAGE_HEIGHT_RST = 11'd24;
  localparam logic [MAP_W-1:0] PIXEL_MAP_RST    = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_MAP    = 2'd2;

  localparam logic [1:0] MODE_FILL = 2'b00;
  localparam logic [1:0] MODE_ALT  = 2'b01;
  localparam logic [1:0] MODE_COPY = 2'b10;
  localparam logic [1:0] MODE_SKIP = 2'b11;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_CTRL,
    PH_FILL,
    PH_ALT,
    PH_COPY,
    PH_DONE,
    PH_ERROR
  } phase_t;

  typedef enum logic {
    CTL_ACCEPT,
    CTL_BURST
  } ctl_state_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_source;
  } src_beat_t;

  typedef struct packed {
    logic [ADDR_W-1:0] pixel_address;
    logic [7:0]        pixel_value;
    logic              write_enable;
    logic              last_of_run;
    logic              image_done;
    logic              source_error;
  } pix_beat_t;

  typedef struct packed {
    logic load_step;  // decode the byte on the source channel, load first result
    logic load_next;  // load the next write of a fill or alternate run
  } ctl_cmd_t;

  typedef struct packed {
    logic burst_more;  // the byte being decoded gives more than one result
    logic burst_last;  // the next run write is the final one
  } dp_status_t;

endpackage

[src/fmsrd_ctrl.sv]
module fmsrd_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   src_valid,
  output logic                   src_ready,
  output logic                   pix_valid,
  input  logic                   pix_ready,
  input  fmsrd_pkg::dp_status_t  status,
  output fmsrd_pkg::ctl_cmd_t    cmd
);

  fmsrd_pkg::ctl_state_t state;
  fmsrd_pkg::ctl_state_t state_next;
  logic                  slot_free;
  logic                  pix_valid_next;

  // output slot is free when empty or being drained this cycle
  assign slot_free = !pix_valid || pix_ready;

  always_comb begin
    state_next = state;
    case (state)
      fmsrd_pkg::CTL_ACCEPT: begin
        if (cmd.load_step && status.burst_more) begin
          state_next = fmsrd_pkg::CTL_BURST;
        end
      end
      fmsrd_pkg::CTL_BURST: begin
        if (cmd.load_next && status.burst_last) begin
          state_next = fmsrd_pkg::CTL_ACCEPT;
        end
      end
      default: state_next = fmsrd_pkg::CTL_ACCEPT;
    endcase
  end

  always_comb begin
    src_ready     = 1'b0;
    cmd.load_step = 1'b0;
    cmd.load_next = 1'b0;
    case (state)
      fmsrd_pkg::CTL_ACCEPT: begin
        src_ready     = slot_free;
        cmd.load_step = src_valid && slot_free;
      end
      fmsrd_pkg::CTL_BURST: begin
        cmd.load_next = slot_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    if (cmd.load_step || cmd.load_next) begin
      pix_valid_next = 1'b1;
    end else if (pix_ready) begin
      pix_valid_next = 1'b0;
    end else begin
      pix_valid_next = pix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= fmsrd_pkg::CTL_ACCEPT;
      pix_valid <= 1'b0;
    end else begin
      state     <= state_next;
      pix_valid <= pix_valid_next;
    end
  end

  a_no_accept_in_burst: assert property (@(posedge clk) disable iff (rst)
    (state == fmsrd_pkg::CTL_BURST) |-> !src_ready)
    else $error("source accepted during a pixel run");

  a_single_stays: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_step && !status.burst_more) |=> (state == fmsrd_pkg::CTL_ACCEPT))
    else $error("single-result byte entered a run");

  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_next && status.burst_last) |=> (state == fmsrd_pkg::CTL_ACCEPT))
    else $error("run did not end on its last write");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (pix_valid && !pix_ready) |=> pix_valid)
    else $error("pending result dropped");

endmodule

[src/fmsrd_datapath.sv]
module fmsrd_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write_en,
  input  logic [fmsrd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fmsrd_pkg::MAP_W-1:0]           cfg_data,
  input  fmsrd_pkg::src_beat_t                  src_data,
  input  fmsrd_pkg::ctl_cmd_t                   cmd,
  output fmsrd_pkg::dp_status_t                 status,
  output fmsrd_pkg::pix_beat_t                  pix_data
);

  // configuration
  logic [fmsrd_pkg::DIM_W-1:0]  image_width;
  logic [fmsrd_pkg::DIM_W-1:0]  image_height;
  logic [fmsrd_pkg::MAP_W-1:0]  pixel_map;

  // decode state
  fmsrd_pkg::phase_t             phase;
  fmsrd_pkg::phase_t             phase_next;
  logic [fmsrd_pkg::HDR_W-1:0]   header_seen;
  logic [fmsrd_pkg::HDR_W-1:0]   header_seen_next;
  logic [fmsrd_pkg::COL_W-1:0]   column;
  logic [fmsrd_pkg::COL_W-1:0]   column_next;
  logic [fmsrd_pkg::DIM_W-1:0]   row_index;
  logic [fmsrd_pkg::DIM_W-1:0]   row_index_next;
  logic [fmsrd_pkg::ADDR_W-1:0]  row_base;
  logic [fmsrd_pkg::ADDR_W-1:0]  row_base_next;
  logic [fmsrd_pkg::RUN_W-1:0]   run_length;
  logic [fmsrd_pkg::RUN_W-1:0]   run_length_next;
  logic [fmsrd_pkg::RUN_W-1:0]   copy_left;
  logic [fmsrd_pkg::RUN_W-1:0]   copy_left_next;

  // run sequencing
  logic [fmsrd_pkg::RUN_W-1:0]   burst_left;
  logic                          burst_alt;

  // step decode
  logic [fmsrd_pkg::RUN_W-1:0]   count;
  logic [fmsrd_pkg::RUN_W:0]     col_add;
  logic [fmsrd_pkg::COL_W-1:0]   col_sum;
  logic                          do_eop;
  logic [fmsrd_pkg::RUN_W-1:0]   n_writes;
  logic                          alt_step;
  logic [7:0]                    px;
  logic                          has_write;

  function automatic logic [7:0] map_pixel(input logic [fmsrd_pkg::MAP_W-1:0] raw,
                                           input logic [7:0] b);
    logic [2:0] offs;
    logic [7:0] res;
    begin
      offs = raw[10:8] + b[2:0];
      if (raw == fmsrd_pkg::PIXEL_MAP_RST) begin
        res = b;
      end else if (!raw[16] && (raw[15:8] != 8'd0)) begin
        res = raw[7:0] + {5'd0, offs};
      end else begin
        res = raw[7:0];
      end
      return res;
    end
  endfunction

  always_comb begin
    phase_next       = phase;
    header_seen_next = header_seen;
    row_index_next   = row_index;
    row_base_next    = row_base;
    run_length_next  = run_length;
    copy_left_next   = copy_left;
    col_add          = '0;
    do_eop           = 1'b0;
    n_writes         = '0;
    alt_step         = 1'b0;
    count            = {1'b0, src_data.data_byte[5:0]} + 7'd1;
    px               = map_pixel(pixel_map, src_data.data_byte);

    case (phase)
      fmsrd_pkg::PH_HEADER: begin
        header_seen_next = header_seen + 3'd1;
        if (header_seen_next >= fmsrd_pkg::HDR_W'(fmsrd_pkg::HDR_BYTES)) begin
          phase_next = fmsrd_pkg::PH_CTRL;
        end
      end
      fmsrd_pkg::PH_CTRL: begin
        case (src_data.data_byte[7:6])
          fmsrd_pkg::MODE_FILL: begin
            run_length_next = count;
            phase_next      = fmsrd_pkg::PH_FILL;
          end
          fmsrd_pkg::MODE_ALT: begin
            run_length_next = count;
            phase_next      = fmsrd_pkg::PH_ALT;
          end
          fmsrd_pkg::MODE_COPY: begin
            copy_left_next = count;
            phase_next     = fmsrd_pkg::PH_COPY;
          end
          default: begin
            col_add = {1'b0, count};
            do_eop  = 1'b1;
          end
        endcase
      end
      fmsrd_pkg::PH_FILL: begin
        n_writes = run_length;
        col_add  = {1'b0, run_length};
        do_eop   = 1'b1;
      end
      fmsrd_pkg::PH_ALT: begin
        n_writes = run_length;
        col_add  = {run_length, 1'b0};
        alt_step = 1'b1;
        do_eop   = 1'b1;
      end
      fmsrd_pkg::PH_COPY: begin
        n_writes = 7'd1;
        col_add  = 8'd1;
        if (copy_left != '0) begin
          copy_left_next = copy_left - 7'd1;
        end
        do_eop = (copy_left_next == '0);
      end
      default: ;
    endcase

    col_sum     = column + fmsrd_pkg::COL_W'(col_add);
    column_next = col_sum;
    if (do_eop) begin
      phase_next = fmsrd_pkg::PH_CTRL;
      if (col_sum >= {1'b0, image_width}) begin
        column_next    = '0;
        row_index_next = row_index + 11'd1;
        row_base_next  = row_base + fmsrd_pkg::ADDR_W'(image_width);
        if (row_index_next >= image_height) begin
          phase_next = fmsrd_pkg::PH_DONE;
        end
      end
    end

    if (src_data.end_of_source && (phase_next != fmsrd_pkg::PH_DONE) &&
        (phase_next != fmsrd_pkg::PH_ERROR)) begin
      phase_next = fmsrd_pkg::PH_ERROR;
    end
  end

  assign has_write         = (n_writes != '0);
  assign status.burst_more = (n_writes > 7'd1);
  assign status.burst_last = (burst_left == 7'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= fmsrd_pkg::IMAGE_WIDTH_RST;
      image_height <= fmsrd_pkg::IMAGE_HEIGHT_RST;
      pixel_map    <= fmsrd_pkg::PIXEL_MAP_RST;
    end else if (cfg_write_en) begin
      case (cfg_index)
        fmsrd_pkg::CFG_IMAGE_WIDTH:  image_width  <= cfg_data[fmsrd_pkg::DIM_W-1:0];
        fmsrd_pkg::CFG_IMAGE_HEIGHT: image_height <= cfg_data[fmsrd_pkg::DIM_W-1:0];
        fmsrd_pkg::CFG_PIXEL_MAP:    pixel_map    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= (fmsrd_pkg::HDR_BYTES > 0) ? fmsrd_pkg::PH_HEADER : fmsrd_pkg::PH_CTRL;
      header_seen <= '0;
      column      <= '0;
      row_index   <= '0;
      row_base    <= '0;
      run_length  <= '0;
      copy_left   <= '0;
      burst_left  <= '0;
      burst_alt   <= 1'b0;
    end else if (cmd.load_step) begin
      phase       <= phase_next;
      header_seen <= header_seen_next;
      column      <= column_next;
      row_index   <= row_index_next;
      row_base    <= row_base_next;
      run_length  <= run_length_next;
      copy_left   <= copy_left_next;
      burst_left  <= n_writes - 7'd1;
      burst_alt   <= alt_step;
    end else if (cmd.load_next) begin
      burst_left <= burst_left - 7'd1;
    end
  end

  // result register: first write (or the no-write beat) on a byte, then run writes
  always_ff @(posedge clk) begin
    if (cmd.load_step) begin
      pix_data.pixel_address <= has_write ?
                                (row_base + fmsrd_pkg::ADDR_W'(column)) : '0;
      pix_data.pixel_value   <= has_write ? px : 8'd0;
      pix_data.write_enable  <= has_write;
      pix_data.last_of_run   <= !status.burst_more;
      pix_data.image_done    <= (phase_next == fmsrd_pkg::PH_DONE);
      pix_data.source_error  <= (phase_next == fmsrd_pkg::PH_ERROR);
    end else if (cmd.load_next) begin
      pix_data.pixel_address <= pix_data.pixel_address +
                                (burst_alt ? 21'd2 : 21'd1);
      pix_data.last_of_run   <= status.burst_last;
    end
  end

endmodule

[src/four_mode_sprite_rle_decoder_core.sv]
// Four-mode sprite RLE decoder. Compressed bytes enter one per beat on the
// src channel; the first four are header and are dropped. Each control byte
// picks fill, alternate, copy or skip with a count of (low six bits)+1, and
// each pixel write leaves as one beat on the pix channel with its unclamped
// address (row base plus column) and mapped value. Every source byte yields
// at least one pix beat: a byte that writes nothing yields a single beat with
// write_enable low, and last_of_run marks the final beat of each byte.
// image_done and source_error are sticky until reset and ride on every beat
// from the byte that set them on. A header, control, copy or ignored byte
// yields one beat; a fill or alternate value byte holds the source until
// all its pixels (1 to 64) are out: the single output register issues one
// write per cycle, while the sink is ready, as the controller walks the run.
// Configuration writes take effect on the next byte; write them only with
// the block idle. There is no clearing pass after reset.
module four_mode_sprite_rle_decoder_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write_en,
  input  logic [fmsrd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fmsrd_pkg::MAP_W-1:0]       cfg_data,
  input  logic                              src_valid,
  output logic                              src_ready,
  input  fmsrd_pkg::src_beat_t              src_data,
  output logic                              pix_valid,
  input  logic                              pix_ready,
  output fmsrd_pkg::pix_beat_t              pix_data
);

  fmsrd_pkg::ctl_cmd_t    cmd;
  fmsrd_pkg::dp_status_t  status;

  // handshake, output slot and run sequencing
  fmsrd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_ready (src_ready),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // registers, decode state, pixel mapping and the result register
  fmsrd_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .src_data     (src_data),
    .cmd          (cmd),
    .status       (status),
    .pix_data     (pix_data)
  );

endmodule

[tb/four_mode_sprite_rle_decoder_core_tb.sv]
`timescale 1ns / 1ps

module four_mode_sprite_rle_decoder_core_tb;
  import fmsrd_pkg::*;

  // Run limits. The tail covers the latency through the block many times
  // over. The cycle limit allows for every byte pulling a full 64-pixel run,
  // each pixel waiting out the longest sink stall.
  localparam int unsigned CYCLE_LIMIT = 20_000_000;
  localparam int TAIL_CYCLES = 20;
  localparam int LONG_HOLD   = 600;
  localparam int PHASE_BYTES = 55;
  localparam int MAX_REPORTS = 50;

  // Predict pixel writes from the accepted source bytes and hold them until
  // the pix channel delivers them.
  class pixel_scoreboard;
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
    logic [MAP_W-1:0]  pmap;
    phase_t            phase;
    int                hdr_count;
    int                col;
    int                row;
    logic [ADDR_W-1:0] base;
    int                run_len;
    int                copy_cnt;
    pix_beat_t         pending_pixels[$];
    int                errors;

    function new();
      width     = IMAGE_WIDTH_RST;
      height    = IMAGE_HEIGHT_RST;
      pmap      = PIXEL_MAP_RST;
      phase     = (HDR_BYTES > 0) ? PH_HEADER : PH_CTRL;
      hdr_count = 0;
      col       = 0;
      row       = 0;
      base      = '0;
      run_len   = 0;
      copy_cnt  = 0;
      errors    = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [MAP_W-1:0] value);
      case (idx)
        CFG_IMAGE_WIDTH:  width  = value[DIM_W-1:0];
        CFG_IMAGE_HEIGHT: height = value[DIM_W-1:0];
        CFG_PIXEL_MAP:    pmap   = value;
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_pixels.size();
    endfunction

    function logic [7:0] map_byte(logic [7:0] b);
      logic [2:0] offset;
      if (pmap == '1) return b;
      if (!pmap[MAP_W-1] && pmap > 17'h000FF) begin
        // only the low three bits of (map >> 8) + byte survive the mask
        offset = pmap[10:8] + b[2:0];
        return pmap[7:0] + {5'd0, offset};
      end
      return pmap[7:0];
    endfunction

    function void close_op();
      phase = PH_CTRL;
      if (col >= int'(width)) begin
        col  = 0;
        row++;
        base = base + ADDR_W'(width);
        if (row >= int'(height)) phase = PH_DONE;
      end
    endfunction

    function void decode_byte(src_beat_t beat);
      pix_beat_t step_q[$];
      pix_beat_t px;
      logic [7:0] value;
      int cnt;
      int stride;
      px = '0;
      case (phase)
        PH_HEADER: begin
          hdr_count++;
          if (hdr_count >= HDR_BYTES) phase = PH_CTRL;
        end
        PH_CTRL: begin
          cnt = int'(beat.data_byte[5:0]) + 1;
          case (beat.data_byte[7:6])
            MODE_FILL: begin
              run_len = cnt;
              phase   = PH_FILL;
            end
            MODE_ALT: begin
              run_len = cnt;
              phase   = PH_ALT;
            end
            MODE_COPY: begin
              copy_cnt = cnt;
              phase    = PH_COPY;
            end
            default: begin
              col += cnt;
              close_op();
            end
          endcase
        end
        PH_FILL, PH_ALT: begin
          stride = (phase == PH_ALT) ? 2 : 1;
          value  = map_byte(beat.data_byte);
          for (int k = 0; k < run_len && k < 64; k++) begin
            px.pixel_address = base + ADDR_W'(col + stride * k);
            px.pixel_value   = value;
            px.write_enable  = 1'b1;
            step_q.push_back(px);
          end
          col += stride * run_len;
          close_op();
        end
        PH_COPY: begin
          px.pixel_address = base + ADDR_W'(col);
          px.pixel_value   = map_byte(beat.data_byte);
          px.write_enable  = 1'b1;
          step_q.push_back(px);
          col++;
          if (copy_cnt > 0) copy_cnt--;
          if (copy_cnt == 0) close_op();
        end
        default: ;
      endcase

      if (beat.end_of_source && phase != PH_DONE && phase != PH_ERROR) phase = PH_ERROR;
      if (step_q.size() == 0) step_q.push_back('0);

      foreach (step_q[i]) begin
        step_q[i].image_done   = (phase == PH_DONE);
        step_q[i].source_error = (phase == PH_ERROR);
        step_q[i].last_of_run  = (i == step_q.size() - 1);
        pending_pixels.push_back(step_q[i]);
      end
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: pix %s expected 0x%0h, got 0x%0h", $time, field, want, got);
      end
    endfunction

    function void check_pixel(pix_beat_t got);
      pix_beat_t want;
      if (pending_pixels.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: pix beat 0x%0h with nothing expected", $time, got);
        return;
      end
      want = pending_pixels.pop_front();
      compare("pixel_address", 32'(want.pixel_address), 32'(got.pixel_address));
      compare("pixel_value", 32'(want.pixel_value), 32'(got.pixel_value));
      compare("write_enable", 32'(want.write_enable), 32'(got.write_enable));
      compare("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
      compare("image_done", 32'(want.image_done), 32'(got.image_done));
      compare("source_error", 32'(want.source_error), 32'(got.source_error));
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_IMAGE_WIDTH;
  logic [MAP_W-1:0]     cfg_data = '0;
  logic                 src_valid = 1'b0;
  logic                 src_ready;
  src_beat_t            src_data = '0;
  logic                 pix_valid;
  logic                 pix_ready = 1'b0;
  pix_beat_t            pix_data;

  pixel_scoreboard sb = new();

  int          bytes_sent = 0;
  bit          tx_gaps_on = 1'b1;
  bit          rx_gaps_on = 1'b1;
  bit          hold_request = 1'b0;
  int unsigned cycle_count = 0;

  four_mode_sprite_rle_decoder_core dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .src_valid    (src_valid),
    .src_ready    (src_ready),
    .src_data     (src_data),
    .pix_valid    (pix_valid),
    .pix_ready    (pix_ready),
    .pix_data     (pix_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Idle spans: mostly short, now and then a long stretch.
  function automatic int idle_span();
    if ($urandom_range(0, 99) < 85) return int'($urandom_range(1, 3));
    return int'($urandom_range(8, 40));
  endfunction

  // Run counts: mostly short so rows keep turning over, a few up to 64.
  function automatic int run_count();
    if ($urandom_range(0, 9) == 0) return int'($urandom_range(1, 64));
    return int'($urandom_range(1, 8));
  endfunction

  // Offer one source byte and hold it until the block takes it. Valid stays
  // high on return unless a random gap dropped it; the caller either offers
  // the next byte in the same step or drops valid through wait_idle.
  task automatic send_byte(input logic [7:0] b, input logic eos);
    src_beat_t beat;
    int gap;
    beat.data_byte     = b;
    beat.end_of_source = eos;
    src_valid <= 1'b1;
    src_data  <= beat;
    @(posedge clk);
    while (!src_ready) @(posedge clk);
    sb.decode_byte(beat);
    bytes_sent++;
    gap = (tx_gaps_on && $urandom_range(0, 1) == 1) ? idle_span() : 0;
    if (gap > 0) begin
      src_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // One complete operation: control byte plus whatever payload it calls for.
  task automatic send_op(input logic [1:0] mode, input int cnt);
    send_byte({mode, 6'(cnt - 1)}, 1'b0);
    case (mode)
      MODE_FILL, MODE_ALT: send_byte(8'($urandom), 1'b0);
      MODE_COPY: repeat (cnt) send_byte(8'($urandom), 1'b0);
      default: ;
    endcase
  endtask

  // Drop valid and wait for every predicted pixel to come out.
  task automatic wait_idle();
    src_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MAP_W-1:0] value);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= value;
    @(posedge clk);
    sb.set_reg(idx, value);
  endtask

  task automatic apply_settings(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                                input logic [MAP_W-1:0] m);
    write_reg(CFG_IMAGE_WIDTH, MAP_W'(w));
    write_reg(CFG_IMAGE_HEIGHT, MAP_W'(h));
    write_reg(CFG_PIXEL_MAP, m);
    cfg_write_en <= 1'b0;
  endtask

  // Mostly whole operations with random content; the rest raw bytes that
  // land wherever the decoder happens to be.
  task automatic random_traffic(input int n_bytes);
    int stop_at;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(0, 99) < 85) send_op(2'($urandom_range(0, 3)), run_count());
      else send_byte(8'($urandom), 1'b0);
    end
  endtask

  // Sink: accept pix beats with random stalls. A hold request parks ready
  // low for a long stretch so the block backs up into the source channel.
  initial begin : pix_sink
    int idle_left;
    bit hold_taken;
    idle_left  = 0;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_taken) begin
        hold_taken = 1'b1;
        idle_left  = LONG_HOLD;
      end
      if (idle_left > 0) begin
        pix_ready <= 1'b0;
        idle_left--;
      end else begin
        pix_ready <= 1'b1;
        if (rx_gaps_on && $urandom_range(0, 4) == 0) idle_left = idle_span();
      end
    end
  end

  // Check every accepted pix beat against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && pix_valid && pix_ready) sb.check_pixel(pix_data);
  end

  // Watchdog.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Header bytes are dropped whatever they hold.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'($urandom), 1'b0);
    send_byte(8'($urandom), 1'b0);

    // Reset settings: width 24, byte passthrough. Cover the smallest and
    // largest fill runs, largest alt and skip runs, and writes past row ends.
    send_byte({MODE_FILL, 6'd0}, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte({MODE_FILL, 6'd63}, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte({MODE_ALT, 6'd2}, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte({MODE_COPY, 6'd1}, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte({MODE_SKIP, 6'd63}, 1'b0);
    send_byte({MODE_ALT, 6'd63}, 1'b0);
    send_byte(8'h5A, 1'b0);
    // advance to column 21, then copy four pixels across the row end
    send_byte({MODE_SKIP, 6'd20}, 1'b0);
    send_byte({MODE_COPY, 6'd3}, 1'b0);
    repeat (4) send_byte(8'($urandom), 1'b0);
    wait_idle();

    // Random phases, each under its own settings. Height stays large so the
    // image only completes when the final phase asks for it.
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: apply_settings(11'd1, 11'h7FF, 17'h00000);
        1: apply_settings(11'd0, 11'h7FF, 17'h000FF);
        2: apply_settings(11'h7FF, 11'd1024, 17'h00100);
        3: apply_settings(11'd24, 11'h7FF, 17'h0FFFF);
        4: apply_settings(11'($urandom_range(1, 40)), 11'h7FF, 17'h10000);
        5: apply_settings(11'd1024, 11'($urandom_range(1500, 2047)), PIXEL_MAP_RST);
        6: apply_settings(11'($urandom_range(0, 2047)), 11'h7FF, 17'($urandom));
        default: apply_settings(11'($urandom_range(2, 64)), 11'h7FF, 17'h1FFFE);
      endcase
      tx_gaps_on = ($urandom_range(0, 3) != 0);
      rx_gaps_on = ($urandom_range(0, 3) != 0);
      if (p == 3) begin
        // keep the source busy while the sink stalls for a long stretch
        tx_gaps_on   = 1'b0;
        hold_request = 1'b1;
      end
      random_traffic(PHASE_BYTES);
      wait_idle();
    end

    // Finish the image one of two ways. Zero height completes it at the next
    // row end; with a wide row instead, the source ends early first. Bytes
    // after either are ignored, end-of-source included.
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
    if ($urandom_range(0, 1) == 1) begin
      apply_settings(11'($urandom_range(0, 64)), 11'd0, 17'($urandom));
      send_op(MODE_SKIP, 64);
      send_byte(8'($urandom), 1'b1);
      send_byte(8'($urandom), 1'b0);
    end else begin
      apply_settings(11'h7FF, 11'd0, PIXEL_MAP_RST);
      send_op(MODE_FILL, run_count());
      send_op(MODE_COPY, run_count());
      send_byte(8'($urandom), 1'b1);
      send_byte(8'($urandom), 1'b0);
    end
    send_byte(8'($urandom), 1'b1);
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
